// ===== hdl/htc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header text canonicalizer package
// Shared types, character constants and the reset state of the scanner.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int unsigned MaxLengthDefault = 65535;
  localparam int unsigned LenWidth         = 16;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef enum logic [2:0] {
    PH_VALUE = 3'b001,
    PH_START = 3'b010,
    PH_NAME  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CTRL = 2'd1,
    STAT_WS_NAME  = 2'd2,
    STAT_NO_EOL   = 2'd3
  } status_e;

  typedef struct packed {
    phase_e                phase;
    logic                  prev_lf;
    logic                  prev_space;
    logic                  lf_emitted;
    status_e               err;
    logic [LenWidth-1:0]   count;
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            byte_count;
    logic [7:0]            first_byte;
    logic [7:0]            second_byte;
    logic                  done;
    status_e               status;
    logic [LenWidth-1:0]   length;
  } result_t;

  localparam state_t StateReset = '{
    phase:      PH_START,
    prev_lf:    1'b0,
    prev_space: 1'b0,
    lf_emitted: 1'b0,
    err:        STAT_OK,
    count:      '0
  };

endpackage

// ===== hdl/header_text_canonicalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header text canonicalizer
// Turns header-block text into its canonical form, one byte per word.
// ----------------------------------------------------------------------------
// The input channel carries one raw byte and an end-of-message flag per word.
// The output channel carries up to two canonical bytes per word, and on the
// closing word of a message also the status and the saturating length.
// An input word that emits nothing and does not end a message produces no
// output word.
// A word passes through two registers: the input register and the result
// register. One word is accepted every cycle while the receiver does not
// stall; the scanner state updates as a word moves from the input register
// to the result register, which sets that rate.
// When the receiver stalls, the result register holds its word, the input
// register fills, and then in_stall_o rises to the sender.
// Reset clears both valid flags and returns the scanner to the start of a
// header name with no error and a zero length.
// ----------------------------------------------------------------------------
module header_text_canonicalizer #(
  parameter int unsigned MAX_LENGTH = htc_pkg::MaxLengthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          end_of_message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    byte_count_o,
  output logic [7:0]                    first_byte_o,
  output logic [7:0]                    second_byte_o,
  output logic                          message_done_o,
  output logic [1:0]                    status_o,
  output logic [htc_pkg::LenWidth-1:0]  out_length_o
);
  import htc_pkg::*;

  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_eom_q;
  logic       advance;
  logic       accept;
  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  result_t    res_q;
  logic       out_valid_q;

  htc_step #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_step (
    .cur_i    (state_q),
    .in_byte_i(a_byte_q),
    .eom_i    (a_eom_q),
    .nxt_o    (state_d),
    .res_o    (res_d)
  );

  assign advance    = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= res_d.valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_byte_q <= in_byte_i;
      a_eom_q  <= end_of_message_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_count_o   = res_q.byte_count;
  assign first_byte_o   = res_q.first_byte;
  assign second_byte_o  = res_q.second_byte;
  assign message_done_o = res_q.done;
  assign status_o       = res_q.status;
  assign out_length_o   = res_q.length;

endmodule

// ===== hdl/htc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header text canonicalizer step
// Next-state and result logic for one input word of header text.
// ----------------------------------------------------------------------------
module htc_step #(
  parameter int unsigned MAX_LENGTH = htc_pkg::MaxLengthDefault
) (
  input  htc_pkg::state_t  cur_i,
  input  logic [7:0]       in_byte_i,
  input  logic             eom_i,
  output htc_pkg::state_t  nxt_o,
  output htc_pkg::result_t res_o
);
  import htc_pkg::*;

  localparam logic [LenWidth-1:0] LenCap =
    (MAX_LENGTH < 65535) ? LenWidth'(MAX_LENGTH) : {LenWidth{1'b1}};

  state_t            nxt;
  logic [1:0]        cnt;
  logic [7:0]        first_b;
  logic [7:0]        second_b;
  logic [7:0]        out_b;
  logic [LenWidth:0] sum;
  logic              lf_now;

  always_comb begin
    nxt      = cur_i;
    cnt      = 2'd0;
    first_b  = 8'h00;
    second_b = 8'h00;
    out_b    = in_byte_i;
    sum      = '0;
    lf_now   = 1'b0;
    if (cur_i.err == STAT_OK) begin
      if (in_byte_i <= ChSpace) begin
        if (cur_i.phase != PH_VALUE) begin
          nxt.err = STAT_WS_NAME;
        end else if (in_byte_i == ChSpace || in_byte_i == ChTab) begin
          if (!cur_i.prev_space) begin
            cnt            = 2'd1;
            first_b        = ChSpace;
            nxt.prev_space = 1'b1;
          end
          nxt.prev_lf = 1'b0;
        end else if (in_byte_i == ChCr) begin
          if (cur_i.prev_lf) begin
            cnt     = 2'd1;
            first_b = ChLf;
          end
          nxt.prev_lf = 1'b0;
        end else if (in_byte_i == ChLf) begin
          nxt.prev_lf = 1'b1;
        end else begin
          nxt.err = STAT_BAD_CTRL;
        end
      end else if (in_byte_i == ChColon && cur_i.phase == PH_NAME) begin
        cnt            = 2'd1;
        first_b        = ChColon;
        nxt.prev_space = 1'b1;
        nxt.phase      = PH_VALUE;
        nxt.prev_lf    = 1'b0;
      end else begin
        nxt.prev_space = 1'b0;
        if (cur_i.prev_lf) begin
          nxt.phase = PH_START;
        end else if (cur_i.phase == PH_START) begin
          nxt.phase = PH_NAME;
        end
        if (nxt.phase != PH_VALUE && in_byte_i >= ChUpA && in_byte_i <= ChUpZ) begin
          out_b = in_byte_i + CaseGap;
        end
        if (cur_i.prev_lf) begin
          cnt      = 2'd2;
          first_b  = ChLf;
          second_b = out_b;
        end else begin
          cnt     = 2'd1;
          first_b = out_b;
        end
        nxt.prev_lf = 1'b0;
      end
      if (eom_i && nxt.err == STAT_OK && nxt.prev_lf) begin
        if (cnt == 2'd0) begin
          first_b = ChLf;
        end else begin
          second_b = ChLf;
        end
        cnt = cnt + 2'd1;
      end
    end
    lf_now = (cnt != 2'd0 && first_b == ChLf) || (cnt == 2'd2 && second_b == ChLf);
    nxt.lf_emitted = cur_i.lf_emitted | lf_now;
    sum = {1'b0, cur_i.count} + (LenWidth+1)'(cnt);
    nxt.count = (sum > {1'b0, LenCap}) ? LenCap : sum[LenWidth-1:0];

    res_o.valid       = eom_i || (cnt != 2'd0);
    res_o.byte_count  = cnt;
    res_o.first_byte  = first_b;
    res_o.second_byte = second_b;
    res_o.done        = eom_i;
    res_o.status      = STAT_OK;
    res_o.length      = '0;
    if (eom_i) begin
      res_o.status = (nxt.err == STAT_OK && !nxt.lf_emitted) ? STAT_NO_EOL : nxt.err;
      res_o.length = nxt.count;
      nxt_o        = StateReset;
    end else begin
      nxt_o = nxt;
    end
  end

endmodule

// ===== tb/tb_header_text_canonicalizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header text canonicalizer testbench
// Feeds header text into the canonicalizer a word at a time and checks every
// output word against a cycle-free model of the scanner kept in the bench,
// or against the word given in the table for a typed row. A short table of
// hand-written words comes first, then random messages that are mostly well
// formed, with bursty input traffic and a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb_header_text_canonicalizer;
  import htc_pkg::*;

  typedef struct packed {
    logic [1:0]  count;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        done;
    status_e     status;
    logic [15:0] length;
  } canon_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eom;
    logic        typed;
    canon_word_t exp;
  } text_word_t;

  localparam int unsigned LenCap   = (MaxLengthDefault < 65535) ? MaxLengthDefault : 65535;
  localparam int          LongHold = 400;
  localparam canon_word_t NoWord   = '{2'd0, 8'h00, 8'h00, 1'b0, STAT_OK, 16'd0};

  localparam text_word_t DirRows [25] = '{
    '{8'h41,   1'b0, 1'b1, '{2'd1, 8'h61, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChColon, 1'b0, 1'b1, '{2'd1, ChColon, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChSpace, 1'b0, 1'b0, NoWord},
    '{8'hFF,   1'b0, 1'b1, '{2'd1, 8'hFF, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChTab,   1'b0, 1'b1, '{2'd1, ChSpace, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChCr,    1'b0, 1'b0, NoWord},
    '{ChLf,    1'b0, 1'b0, NoWord},
    '{8'h5A,   1'b0, 1'b1, '{2'd2, ChLf, 8'h7A, 1'b0, STAT_OK, 16'd0}},
    '{ChColon, 1'b0, 1'b1, '{2'd1, ChColon, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChColon, 1'b0, 1'b1, '{2'd1, ChColon, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{8'h41,   1'b0, 1'b1, '{2'd1, 8'h41, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChLf,    1'b0, 1'b0, NoWord},
    '{ChCr,    1'b0, 1'b1, '{2'd1, ChLf, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChSpace, 1'b0, 1'b1, '{2'd1, ChSpace, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{8'h62,   1'b0, 1'b1, '{2'd1, 8'h62, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChLf,    1'b1, 1'b0, NoWord},
    '{ChSpace, 1'b1, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b1, STAT_WS_NAME, 16'd0}},
    '{8'h00,   1'b0, 1'b0, NoWord},
    '{8'h78,   1'b1, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b1, STAT_WS_NAME, 16'd0}},
    '{8'h68,   1'b0, 1'b1, '{2'd1, 8'h68, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{ChColon, 1'b0, 1'b1, '{2'd1, ChColon, 8'h00, 1'b0, STAT_OK, 16'd0}},
    '{8'h01,   1'b0, 1'b0, NoWord},
    '{8'h6B,   1'b1, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b1, STAT_BAD_CTRL, 16'd2}},
    '{8'h71,   1'b1, 1'b1, '{2'd1, 8'h71, 8'h00, 1'b1, STAT_NO_EOL, 16'd1}},
    '{ChLf,    1'b1, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b1, STAT_WS_NAME, 16'd0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  byte_count_o;
  logic [7:0]  first_byte_o;
  logic [7:0]  second_byte_o;
  logic        message_done_o;
  logic [1:0]  status_o;
  logic [15:0] out_length_o;

  logic        word_typed;
  canon_word_t word_exp;

  text_word_t  raw_word_q [$];
  canon_word_t canon_expected_q [$];
  int          mismatch_count;
  int          long_holds_wanted;
  int          long_holds_done;

  phase_e      sc_phase;
  logic        sc_after_lf;
  logic        sc_after_space;
  logic        sc_lf_out;
  status_e     sc_err;
  int unsigned sc_len;
  logic [7:0]  emit_buf [2];
  int          emit_n;

  header_text_canonicalizer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_count_o    (byte_count_o),
    .first_byte_o    (first_byte_o),
    .second_byte_o   (second_byte_o),
    .message_done_o  (message_done_o),
    .status_o        (status_o),
    .out_length_o    (out_length_o)
  );

  function automatic void scan_reset();
    sc_phase       = PH_START;
    sc_after_lf    = 1'b0;
    sc_after_space = 1'b0;
    sc_lf_out      = 1'b0;
    sc_err         = STAT_OK;
    sc_len         = 0;
  endfunction

  function automatic void emit_canon(logic [7:0] c);
    if (emit_n < 2) begin
      emit_buf[emit_n] = c;
      emit_n++;
    end
    if (sc_len < LenCap) sc_len++;
    if (c == ChLf) sc_lf_out = 1'b1;
  endfunction

  function automatic bit canon_step(input logic [7:0] raw, input logic eom,
                                    output canon_word_t w);
    logic [7:0] b;
    status_e    st;
    b = raw;
    w = NoWord;
    emit_n = 0;
    emit_buf[0] = 8'h00;
    emit_buf[1] = 8'h00;
    if (sc_err == STAT_OK) begin
      if (b <= ChSpace) begin
        if (sc_phase != PH_VALUE) begin
          sc_err = STAT_WS_NAME;
        end else if (b == ChSpace || b == ChTab) begin
          if (!sc_after_space) begin
            emit_canon(ChSpace);
            sc_after_space = 1'b1;
          end
          sc_after_lf = 1'b0;
        end else if (b == ChCr) begin
          if (sc_after_lf) emit_canon(ChLf);
          sc_after_lf = 1'b0;
        end else if (b == ChLf) begin
          sc_after_lf = 1'b1;
        end else begin
          sc_err = STAT_BAD_CTRL;
        end
      end else if (b == ChColon && sc_phase == PH_NAME) begin
        emit_canon(ChColon);
        sc_after_space = 1'b1;
        sc_phase       = PH_VALUE;
        sc_after_lf    = 1'b0;
      end else begin
        sc_after_space = 1'b0;
        if (sc_phase == PH_START) sc_phase = PH_NAME;
        if (sc_after_lf) begin
          emit_canon(ChLf);
          sc_phase = PH_START;
        end
        if (sc_phase != PH_VALUE && b >= ChUpA && b <= ChUpZ) b = b + CaseGap;
        emit_canon(b);
        sc_after_lf = 1'b0;
      end
      if (eom && sc_err == STAT_OK && sc_after_lf) emit_canon(ChLf);
    end
    if (!eom && emit_n == 0) return 1'b0;
    w.count  = 2'(emit_n);
    w.first  = emit_buf[0];
    w.second = emit_buf[1];
    if (eom) begin
      st = sc_err;
      if (st == STAT_OK && !sc_lf_out) st = STAT_NO_EOL;
      w.done   = 1'b1;
      w.status = st;
      w.length = 16'(sc_len);
      scan_reset();
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: mismatch, %s", $time, what);
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  always @(posedge clk_i) begin : monitor_p
    canon_word_t want;
    canon_word_t pred;
    bit          has_word;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (canon_expected_q.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          want = canon_expected_q.pop_front();
          check_field("byte_count", 16'(byte_count_o), 16'(want.count));
          check_field("first_byte", 16'(first_byte_o), 16'(want.first));
          check_field("second_byte", 16'(second_byte_o), 16'(want.second));
          check_field("message_done", 16'(message_done_o), 16'(want.done));
          check_field("status", 16'(status_o), 16'(want.status));
          check_field("out_length", out_length_o, want.length);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        has_word = canon_step(in_byte_i, end_of_message_i, pred);
        if (word_typed) canon_expected_q.push_back(word_exp);
        else if (has_word) canon_expected_q.push_back(pred);
      end
    end
  end

  function automatic logic [7:0] blank_char();
    return ($urandom_range(1) != 0) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(2))
      0: c = 8'($urandom_range(ChUpA, ChUpZ));
      1: c = 8'($urandom_range(8'h61, 8'h7A));
      default: begin
        c = 8'($urandom_range(8'h21, 8'hFF));
        if (c == ChColon) c = 8'h2D;
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    case ($urandom_range(7))
      0: return blank_char();
      1: return ChColon;
      default: return 8'($urandom_range(8'h21, 8'hFF));
    endcase
  endfunction

  task automatic queue_message();
    logic [7:0] text [$];
    int         kind;
    int         lines;
    int         n;
    kind = $urandom_range(9);
    if (kind == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) text.push_back(8'($urandom_range(255)));
    end else begin
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) begin
        n = $urandom_range(1, 8);
        repeat (n) text.push_back(name_char());
        text.push_back(ChColon);
        repeat ($urandom_range(2)) text.push_back(blank_char());
        for (int seg = 0; seg <= (($urandom_range(4) == 0) ? 1 : 0); seg++) begin
          if (seg != 0) text.push_back(blank_char());
          n = $urandom_range(0, 10);
          repeat (n) text.push_back(value_char());
          case ($urandom_range(9))
            0, 1, 2, 3, 4: text.push_back(ChLf);
            5, 6, 7: begin
              text.push_back(ChCr);
              text.push_back(ChLf);
            end
            8: begin
              text.push_back(ChLf);
              text.push_back(ChCr);
            end
            default: ;
          endcase
        end
      end
      if ($urandom_range(3) == 0) begin
        text.push_back(ChCr);
        text.push_back(ChLf);
      end
      if (kind == 1) begin
        text[$urandom_range(text.size() - 1)] = 8'($urandom_range(0, 31));
      end else begin
        foreach (text[i]) if ($urandom_range(49) == 0) text[i] = 8'($urandom_range(255));
      end
    end
    foreach (text[i]) raw_word_q.push_back('{text[i], i == text.size() - 1, 1'b0, NoWord});
  endtask

  // Entered and left at a falling edge; valid holds until each word is taken.
  task automatic drive_words();
    text_word_t w;
    int         burst;
    int         gap;
    burst = 0;
    while (raw_word_q.size() != 0) begin
      if (burst == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst = ($urandom_range(7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      end
      w = raw_word_q.pop_front();
      in_byte_i        <= w.b;
      end_of_message_i <= w.eom;
      word_typed       <= w.typed;
      word_exp         <= w.exp;
      in_valid_i       <= 1'b1;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
      burst--;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (canon_expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : receiver_p
    int mode;
    int left;
    bit stall_now;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_holds_done < long_holds_wanted) begin
        long_holds_done++;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3);
          left = $urandom_range(10, 150);
        end
        left--;
        case (mode)
          0: stall_now = 1'b0;
          1: stall_now = ($urandom_range(3) == 0);
          2: stall_now = ($urandom_range(3) != 0);
          default: stall_now = ~out_stall_i;
        endcase
        out_stall_i <= stall_now;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[header_text_canonicalizer] ERROR");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_byte_i         = 8'h00;
    end_of_message_i  = 1'b0;
    word_typed        = 1'b0;
    word_exp          = NoWord;
    mismatch_count    = 0;
    long_holds_wanted = 0;
    long_holds_done   = 0;
    scan_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirRows[i]) raw_word_q.push_back(DirRows[i]);
    drive_words();
    wait_drained();

    while (raw_word_q.size() < 1300) queue_message();
    long_holds_wanted++;
    drive_words();
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && canon_expected_q.size() == 0) begin
      $display("[header_text_canonicalizer] OK");
    end else begin
      $display("[header_text_canonicalizer] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/htc_pkg.sv
hdl/htc_step.sv
hdl/header_text_canonicalizer.sv
tb/tb_header_text_canonicalizer.sv
